// ===== hdl/tps_pkg.sv =====
package tps_pkg;

  localparam int NUM_OPERATORS = 6;
  localparam int LENGTH_BITS   = 16;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_HEADER = 3'd1;
  localparam logic [2:0] KIND_ATTR   = 3'd2;
  localparam logic [2:0] KIND_ID     = 3'd3;
  localparam logic [2:0] KIND_PATH   = 3'd4;
  localparam logic [2:0] KIND_VALUE  = 3'd5;
  localparam logic [2:0] KIND_ERROR  = 3'd6;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_HEADER   = 3'd1;
  localparam logic [2:0] ERR_TRUNC    = 3'd2;
  localparam logic [2:0] ERR_OPERATOR = 3'd3;
  localparam logic [2:0] ERR_TYPE     = 3'd4;

  localparam logic [2:0] REG_VERSION = 3'd0;
  localparam logic [2:0] REG_BOOL    = 3'd1;
  localparam logic [2:0] REG_INT     = 3'd2;
  localparam logic [2:0] REG_FLOAT   = 3'd3;
  localparam logic [2:0] REG_STRING  = 3'd4;
  localparam logic [2:0] REG_OBJECT  = 3'd5;
  localparam logic [2:0] REG_ARRAY   = 3'd6;

  localparam logic [7:0] FLAG_ENABLE = 8'h01;
  localparam logic [7:0] FLAG_TYPE   = 8'h0E;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ver_ok;
    logic       op_ok;
    logic       nonzero;
  } word_t;

  typedef struct packed {
    logic [2:0] bool_code;
    logic [2:0] int_code;
    logic [2:0] float_code;
    logic [2:0] string_code;
    logic [2:0] object_code;
    logic [2:0] array_code;
  } codes_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       enabled;
    logic [2:0] op_code;
    logic [2:0] vtype;
    logic       field_end;
    logic       record_end;
    logic [7:0] records_left;
    logic       stream_end;
    logic [2:0] error;
  } result_t;

endpackage

// ===== hdl/tps_front.sv =====
module tps_front (
  input  logic           push,
  output logic           full,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  logic [7:0]     codec_version,
  output logic           wr,
  output tps_pkg::word_t wr_word,
  input  logic           link_full
);

  assign full = link_full;
  assign wr   = push && !link_full;

  always_comb begin
    wr_word.data    = in_byte;
    wr_word.last    = in_last;
    wr_word.ver_ok  = (in_byte == codec_version) && !in_last;
    wr_word.op_ok   = in_byte < 8'(tps_pkg::NUM_OPERATORS);
    wr_word.nonzero = in_byte != 8'd0;
  end

endmodule

// ===== hdl/tps_link_queue.sv =====
module tps_link_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  tps_pkg::word_t wr_word,
  output logic           full,
  input  logic           rd,
  output tps_pkg::word_t rd_word,
  output logic           empty
);

  tps_pkg::word_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_word = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(wr) - 2'(rd);
    end
  end

endmodule

// ===== hdl/tps_back.sv =====
module tps_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             link_empty,
  input  tps_pkg::word_t   word,
  output logic             rd,
  input  tps_pkg::codes_t  codes,
  input  logic             pop,
  output logic             empty,
  output tps_pkg::result_t head
);

  localparam logic [3:0] PH_VER  = 4'd0;
  localparam logic [3:0] PH_CNT  = 4'd1;
  localparam logic [3:0] PH_FLG  = 4'd2;
  localparam logic [3:0] PH_OPR  = 4'd3;
  localparam logic [3:0] PH_IDL  = 4'd4;
  localparam logic [3:0] PH_IDH  = 4'd5;
  localparam logic [3:0] PH_IDD  = 4'd6;
  localparam logic [3:0] PH_PTL  = 4'd7;
  localparam logic [3:0] PH_PTH  = 4'd8;
  localparam logic [3:0] PH_PTD  = 4'd9;
  localparam logic [3:0] PH_VFX  = 4'd10;
  localparam logic [3:0] PH_VLL  = 4'd11;
  localparam logic [3:0] PH_VLH  = 4'd12;
  localparam logic [3:0] PH_VLD  = 4'd13;
  localparam logic [3:0] PH_DONE = 4'd14;
  localparam logic [3:0] PH_SKIP = 4'd15;

  localparam int LB = tps_pkg::LENGTH_BITS;

  logic [3:0]    phase, phase_next;
  logic [7:0]    records_left, records_left_next;
  logic [LB-1:0] field_left, field_left_next;
  logic [7:0]    length_low, length_low_next;
  logic          rec_enabled, rec_enabled_next;
  logic [2:0]    rec_type, rec_type_next;

  tps_pkg::result_t res;
  tps_pkg::result_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       out_pop;
  logic       step;

  logic          end_fld;
  logic [3:0]    end_ph;
  logic [15:0]   len_full;
  logic [LB-1:0] field_dec;
  logic [7:0]    records_dec;

  assign out_pop = pop && (count != 2'd0);
  assign step    = !link_empty && ((count != 2'd2) || out_pop);
  assign rd      = step;
  assign empty   = count == 2'd0;
  assign head    = mem[rptr];

  assign len_full    = {word.data, length_low};
  assign field_dec   = field_left - LB'(1);
  assign records_dec = records_left - 8'd1;

  always_comb begin
    phase_next        = phase;
    records_left_next = records_left;
    field_left_next   = field_left;
    length_low_next   = length_low;
    rec_enabled_next  = rec_enabled;
    rec_type_next     = rec_type;
    end_fld           = 1'b0;
    end_ph            = PH_VLD;
    res.kind          = tps_pkg::KIND_NONE;
    res.data          = 8'd0;
    res.op_code       = 3'd0;
    res.field_end     = 1'b0;
    res.record_end    = 1'b0;
    res.error         = tps_pkg::ERR_NONE;

    unique case (phase)
      PH_VER: begin
        if (!word.ver_ok) begin
          res.error = tps_pkg::ERR_HEADER;
        end else begin
          phase_next = PH_CNT;
        end
      end
      PH_CNT: begin
        records_left_next = word.data;
        res.kind          = tps_pkg::KIND_HEADER;
        res.data          = word.data;
        phase_next        = word.nonzero ? PH_FLG : PH_DONE;
      end
      PH_FLG: begin
        rec_enabled_next = |(word.data & tps_pkg::FLAG_ENABLE);
        rec_type_next    = word.data[3:1];
        phase_next       = PH_OPR;
      end
      PH_OPR: begin
        if (!word.op_ok) begin
          res.error = tps_pkg::ERR_OPERATOR;
        end else begin
          res.kind    = tps_pkg::KIND_ATTR;
          res.op_code = word.data[2:0];
          phase_next  = PH_IDL;
        end
      end
      PH_IDL, PH_PTL, PH_VLL: begin
        length_low_next = word.data;
        phase_next      = phase + 4'd1;
      end
      PH_IDH, PH_PTH, PH_VLH: begin
        field_left_next = len_full[LB-1:0];
        if (len_full[LB-1:0] == '0) begin
          end_fld = 1'b1;
          end_ph  = phase + 4'd1;
        end else begin
          phase_next = phase + 4'd1;
        end
      end
      PH_IDD, PH_PTD, PH_VFX, PH_VLD: begin
        if (phase == PH_IDD) begin
          res.kind = tps_pkg::KIND_ID;
        end else if (phase == PH_PTD) begin
          res.kind = tps_pkg::KIND_PATH;
        end else begin
          res.kind = tps_pkg::KIND_VALUE;
        end
        res.data = word.data;
        if (phase == PH_VFX && rec_type == codes.bool_code) begin
          res.data = {7'd0, word.nonzero};
        end
        field_left_next = field_dec;
        if (field_dec == '0) begin
          end_fld = 1'b1;
          end_ph  = (phase == PH_VFX) ? PH_VLD : phase;
        end
      end
      PH_DONE, PH_SKIP: begin
      end
      default: begin
      end
    endcase

    if (end_fld) begin
      res.field_end = 1'b1;
      if (end_ph == PH_IDD) begin
        phase_next = PH_PTL;
      end else if (end_ph == PH_PTD) begin
        if (rec_type == codes.bool_code) begin
          field_left_next = LB'(1);
          phase_next      = PH_VFX;
        end else if (rec_type == codes.int_code || rec_type == codes.float_code) begin
          field_left_next = LB'(4);
          phase_next      = PH_VFX;
        end else if (rec_type == codes.string_code || rec_type == codes.object_code
                     || rec_type == codes.array_code) begin
          phase_next = PH_VLL;
        end else begin
          res.error = tps_pkg::ERR_TYPE;
        end
      end else begin
        res.record_end    = 1'b1;
        records_left_next = records_dec;
        phase_next        = (records_dec != 8'd0) ? PH_FLG : PH_DONE;
      end
    end

    if (res.error == tps_pkg::ERR_NONE && word.last
        && phase_next != PH_DONE && phase_next != PH_SKIP) begin
      res.error = tps_pkg::ERR_TRUNC;
    end
    if (res.error != tps_pkg::ERR_NONE) begin
      res.kind   = tps_pkg::KIND_ERROR;
      res.data   = 8'd0;
      phase_next = PH_SKIP;
    end

    res.enabled      = rec_enabled_next;
    res.vtype        = rec_type_next;
    res.records_left = records_left_next;
    res.stream_end   = word.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_VER;
      records_left <= 8'd0;
      field_left   <= '0;
      length_low   <= 8'd0;
      rec_enabled  <= 1'b0;
      rec_type     <= 3'd0;
    end else if (step) begin
      if (word.last) begin
        phase        <= PH_VER;
        records_left <= 8'd0;
        field_left   <= '0;
        length_low   <= 8'd0;
        rec_enabled  <= 1'b0;
        rec_type     <= 3'd0;
      end else begin
        phase        <= phase_next;
        records_left <= records_left_next;
        field_left   <= field_left_next;
        length_low   <= length_low_next;
        rec_enabled  <= rec_enabled_next;
        rec_type     <= rec_type_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      mem[wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (step) begin
        wptr <= ~wptr;
      end
      if (out_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(step) - 2'(out_pop);
    end
  end

endmodule

// ===== hdl/trigger_record_stream_parser.sv =====
// Trigger record stream parser.
// Input queue side: drive in_byte/in_last with push; a word is taken at a
// clock edge with push high and full low. in_last marks the buffer's final
// byte, after which the parser expects a new version byte.
// Result queue side: while empty is low the oldest result sits on the out_*
// ports; pop at a clock edge with empty low takes it. Every input word gives
// exactly one result word.
// A taken word is registered in the link queue, its result in the two-entry
// result queue; one word per cycle while pop keeps up. The front classifies
// each byte against the version and operator limits, a two-entry queue
// feeds the back, and the back updates the parse state and writes results.
// When pop is held low the result queue fills, the back stops draining the
// link queue, and full rises two words later; nothing is dropped.
// Configuration: APB registers at 4*i (version, then the six value type
// codes); write them only while the block is idle. pready is always high.
// Reset (rst, synchronous) empties both queues, returns the parser to the
// version byte and restores the register defaults.
module trigger_record_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data,
  output logic        out_enabled,
  output logic [2:0]  out_op_code,
  output logic [2:0]  out_value_type,
  output logic        out_field_end,
  output logic        out_record_end,
  output logic [7:0]  out_records_left,
  output logic        out_stream_end,
  output logic [2:0]  out_error
);

  logic [7:0]       codec_version;
  tps_pkg::codes_t  codes;
  logic             cfg_wr;
  logic [2:0]       cfg_index;
  logic             wr;
  tps_pkg::word_t   wr_word;
  logic             link_full;
  logic             link_empty;
  logic             rd;
  tps_pkg::word_t   rd_word;
  tps_pkg::result_t head;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_version     <= 8'd1;
      codes.bool_code   <= 3'd0;
      codes.int_code    <= 3'd1;
      codes.float_code  <= 3'd2;
      codes.string_code <= 3'd3;
      codes.object_code <= 3'd4;
      codes.array_code  <= 3'd5;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        tps_pkg::REG_VERSION: codec_version     <= pwdata[7:0];
        tps_pkg::REG_BOOL:    codes.bool_code   <= pwdata[2:0];
        tps_pkg::REG_INT:     codes.int_code    <= pwdata[2:0];
        tps_pkg::REG_FLOAT:   codes.float_code  <= pwdata[2:0];
        tps_pkg::REG_STRING:  codes.string_code <= pwdata[2:0];
        tps_pkg::REG_OBJECT:  codes.object_code <= pwdata[2:0];
        tps_pkg::REG_ARRAY:   codes.array_code  <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      tps_pkg::REG_VERSION: prdata = {24'd0, codec_version};
      tps_pkg::REG_BOOL:    prdata = {29'd0, codes.bool_code};
      tps_pkg::REG_INT:     prdata = {29'd0, codes.int_code};
      tps_pkg::REG_FLOAT:   prdata = {29'd0, codes.float_code};
      tps_pkg::REG_STRING:  prdata = {29'd0, codes.string_code};
      tps_pkg::REG_OBJECT:  prdata = {29'd0, codes.object_code};
      tps_pkg::REG_ARRAY:   prdata = {29'd0, codes.array_code};
      default:              prdata = 32'd0;
    endcase
  end

  tps_front u_front (
    .push          (push),
    .full          (full),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .codec_version (codec_version),
    .wr            (wr),
    .wr_word       (wr_word),
    .link_full     (link_full)
  );

  tps_link_queue u_link (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .wr_word (wr_word),
    .full    (link_full),
    .rd      (rd),
    .rd_word (rd_word),
    .empty   (link_empty)
  );

  tps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .link_empty (link_empty),
    .word       (rd_word),
    .rd         (rd),
    .codes      (codes),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  assign out_kind         = head.kind;
  assign out_data         = head.data;
  assign out_enabled      = head.enabled;
  assign out_op_code      = head.op_code;
  assign out_value_type   = head.vtype;
  assign out_field_end    = head.field_end;
  assign out_record_end   = head.record_end;
  assign out_records_left = head.records_left;
  assign out_stream_end   = head.stream_end;
  assign out_error        = head.error;

endmodule

// ===== hdl/tps_checker.sv =====
module tps_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [2:0] out_kind,
  input logic [7:0] out_data,
  input logic [2:0] out_op_code,
  input logic [2:0] out_error
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_error_kind: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind == tps_pkg::KIND_ERROR) |->
      (out_data == 8'd0 && out_error != tps_pkg::ERR_NONE))
    else $error("error word carries data or no error code");

  a_no_stray_error: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind != tps_pkg::KIND_ERROR) |-> out_error == tps_pkg::ERR_NONE)
    else $error("error code on a non-error word");

  a_op_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind == tps_pkg::KIND_ATTR) |->
      out_op_code < 3'(tps_pkg::NUM_OPERATORS))
    else $error("operator out of range on attribute word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_data)))
    else $error("waiting result word changed");

endmodule

bind trigger_record_stream_parser tps_checker u_tps_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .out_kind    (out_kind),
  .out_data    (out_data),
  .out_op_code (out_op_code),
  .out_error   (out_error)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [3:0] {
    P_VERSION, P_COUNT, P_FLAGS, P_OPER,
    P_ID_LO, P_ID_HI, P_ID_DATA,
    P_PATH_LO, P_PATH_HI, P_PATH_DATA,
    P_VAL_FIXED, P_VAL_LO, P_VAL_HI, P_VAL_DATA,
    P_DONE, P_SKIP
  } phase_t;

  typedef enum logic [1:0] {VC_BOOL, VC_WORD, VC_PREFIXED, VC_UNKNOWN} vclass_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = '0;
  logic        in_last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_data;
  logic        out_enabled;
  logic [2:0]  out_op_code;
  logic [2:0]  out_value_type;
  logic        out_field_end;
  logic        out_record_end;
  logic [7:0]  out_records_left;
  logic        out_stream_end;
  logic [2:0]  out_error;

  trigger_record_stream_parser i_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_data         (out_data),
    .out_enabled      (out_enabled),
    .out_op_code      (out_op_code),
    .out_value_type   (out_value_type),
    .out_field_end    (out_field_end),
    .out_record_end   (out_record_end),
    .out_records_left (out_records_left),
    .out_stream_end   (out_stream_end),
    .out_error        (out_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]  cfg_version;
  logic [2:0]  type_code [7];
  phase_t      phase;
  logic [7:0]  rec_left;
  logic [15:0] field_left;
  logic [7:0]  len_lo;
  logic        rec_en;
  logic [2:0]  rec_vt;

  tps_pkg::result_t pending_results [$];
  tps_pkg::result_t exp_r;
  logic [7:0]  frame [$];
  int          mismatches = 0;
  int          words_sent = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;

  function automatic vclass_t value_class(input logic [2:0] vt);
    if (vt == type_code[tps_pkg::REG_BOOL]) return VC_BOOL;
    if (vt == type_code[tps_pkg::REG_INT] || vt == type_code[tps_pkg::REG_FLOAT])
      return VC_WORD;
    if (vt == type_code[tps_pkg::REG_STRING] || vt == type_code[tps_pkg::REG_OBJECT] ||
        vt == type_code[tps_pkg::REG_ARRAY]) return VC_PREFIXED;
    return VC_UNKNOWN;
  endfunction

  function automatic void clear_parse();
    phase = P_VERSION;
    rec_left = '0;
    field_left = '0;
    len_lo = '0;
    rec_en = 1'b0;
    rec_vt = '0;
  endfunction

  function automatic void close_field(input phase_t fph, inout logic fe, inout logic re,
                                      inout logic [2:0] err);
    fe = 1'b1;
    if (fph == P_ID_DATA) begin
      phase = P_PATH_LO;
    end else if (fph == P_PATH_DATA) begin
      case (value_class(rec_vt))
        VC_BOOL: begin
          field_left = 16'd1;
          phase = P_VAL_FIXED;
        end
        VC_WORD: begin
          field_left = 16'd4;
          phase = P_VAL_FIXED;
        end
        VC_PREFIXED: phase = P_VAL_LO;
        default: err = tps_pkg::ERR_TYPE;
      endcase
    end else begin
      re = 1'b1;
      rec_left = rec_left - 8'd1;
      phase = (rec_left != 0) ? P_FLAGS : P_DONE;
    end
  endfunction

  function automatic tps_pkg::result_t parse_byte(input logic [7:0] b, input logic l);
    tps_pkg::result_t r;
    logic        fe;
    logic        re;
    logic [2:0]  err;
    logic [7:0]  flag_vt;
    logic [31:0] len_full;
    phase_t      data_ph;
    r = '0;
    fe = 1'b0;
    re = 1'b0;
    err = tps_pkg::ERR_NONE;
    case (phase)
      P_VERSION: begin
        if (b != cfg_version || l) err = tps_pkg::ERR_HEADER;
        else phase = P_COUNT;
      end
      P_COUNT: begin
        rec_left = b;
        r.kind = tps_pkg::KIND_HEADER;
        r.data = b;
        phase = (b != 0) ? P_FLAGS : P_DONE;
      end
      P_FLAGS: begin
        rec_en = |(b & tps_pkg::FLAG_ENABLE);
        flag_vt = (b & tps_pkg::FLAG_TYPE) >> 1;
        rec_vt = flag_vt[2:0];
        phase = P_OPER;
      end
      P_OPER: begin
        if (b >= tps_pkg::NUM_OPERATORS) begin
          err = tps_pkg::ERR_OPERATOR;
        end else begin
          r.kind = tps_pkg::KIND_ATTR;
          r.op_code = b[2:0];
          phase = P_ID_LO;
        end
      end
      P_ID_LO, P_PATH_LO, P_VAL_LO: begin
        len_lo = b;
        phase = (phase == P_ID_LO) ? P_ID_HI : (phase == P_PATH_LO) ? P_PATH_HI : P_VAL_HI;
      end
      P_ID_HI, P_PATH_HI, P_VAL_HI: begin
        data_ph = (phase == P_ID_HI) ? P_ID_DATA :
                  (phase == P_PATH_HI) ? P_PATH_DATA : P_VAL_DATA;
        len_full = {16'd0, b, len_lo} & ((32'd1 << tps_pkg::LENGTH_BITS) - 32'd1);
        field_left = len_full[15:0];
        if (field_left == 0) close_field(data_ph, fe, re, err);
        else phase = data_ph;
      end
      P_ID_DATA, P_PATH_DATA, P_VAL_FIXED, P_VAL_DATA: begin
        r.kind = (phase == P_ID_DATA) ? tps_pkg::KIND_ID :
                 (phase == P_PATH_DATA) ? tps_pkg::KIND_PATH : tps_pkg::KIND_VALUE;
        r.data = b;
        if (phase == P_VAL_FIXED && value_class(rec_vt) == VC_BOOL) r.data = {7'd0, b != 0};
        field_left = field_left - 16'd1;
        if (field_left == 0) close_field((phase == P_VAL_FIXED) ? P_VAL_DATA : phase, fe, re, err);
      end
      default: ;
    endcase
    if (err == tps_pkg::ERR_NONE && l && phase != P_DONE && phase != P_SKIP)
      err = tps_pkg::ERR_TRUNC;
    if (err != tps_pkg::ERR_NONE) begin
      r.kind = tps_pkg::KIND_ERROR;
      r.data = '0;
      phase = P_SKIP;
    end
    r.enabled = rec_en;
    r.vtype = rec_vt;
    r.field_end = fe;
    r.record_end = re;
    r.records_left = rec_left;
    r.stream_end = l;
    r.error = err;
    if (l) clear_parse();
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] expected,
                             input logic [7:0] actual);
    if (expected != actual) begin
      $display("%0t: %s expected %0h got %0h", $time, name, expected, actual);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result expected none got kind %0h", $time, out_kind);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("out_kind", 8'(exp_r.kind), 8'(out_kind));
        check_field("out_data", exp_r.data, out_data);
        check_field("out_enabled", 8'(exp_r.enabled), 8'(out_enabled));
        check_field("out_op_code", 8'(exp_r.op_code), 8'(out_op_code));
        check_field("out_value_type", 8'(exp_r.vtype), 8'(out_value_type));
        check_field("out_field_end", 8'(exp_r.field_end), 8'(out_field_end));
        check_field("out_record_end", 8'(exp_r.record_end), 8'(out_record_end));
        check_field("out_records_left", exp_r.records_left, out_records_left);
        check_field("out_stream_end", 8'(exp_r.stream_end), 8'(out_stream_end));
        check_field("out_error", 8'(exp_r.error), 8'(out_error));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(negedge clk); while (full);
    @(posedge clk);
    pending_results.push_back(parse_byte(b, l));
    words_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send_word(frame[i], i == frame.size() - 1);
    frame.delete();
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    if (idx == tps_pkg::REG_VERSION) cfg_version = value;
    else type_code[idx] = value[2:0];
  endtask

  task automatic write_config(input logic [7:0] version, input logic [2:0] c_bool,
                              input logic [2:0] c_int, input logic [2:0] c_float,
                              input logic [2:0] c_string, input logic [2:0] c_object,
                              input logic [2:0] c_array);
    drain();
    write_reg(tps_pkg::REG_VERSION, version);
    write_reg(tps_pkg::REG_BOOL, {5'd0, c_bool});
    write_reg(tps_pkg::REG_INT, {5'd0, c_int});
    write_reg(tps_pkg::REG_FLOAT, {5'd0, c_float});
    write_reg(tps_pkg::REG_STRING, {5'd0, c_string});
    write_reg(tps_pkg::REG_OBJECT, {5'd0, c_object});
    write_reg(tps_pkg::REG_ARRAY, {5'd0, c_array});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_len(input int max_len);
    if ($urandom_range(99) < 2) return 16'($urandom_range(256, 300));
    return 16'($urandom_range(0, max_len));
  endfunction

  task automatic add_field(input logic [15:0] n);
    frame.push_back(n[7:0]);
    frame.push_back(n[15:8]);
    repeat (n) frame.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_record();
    logic [2:0] vt;
    logic [7:0] op;
    if ($urandom_range(99) < 85)
      vt = type_code[3'($urandom_range(tps_pkg::REG_BOOL, tps_pkg::REG_ARRAY))];
    else vt = 3'($urandom_range(7));
    if ($urandom_range(99) < 92) op = 8'($urandom_range(0, tps_pkg::NUM_OPERATORS - 1));
    else op = 8'($urandom_range(tps_pkg::NUM_OPERATORS, 255));
    frame.push_back({4'($urandom_range(15)), vt, 1'($urandom_range(1))});
    frame.push_back(op);
    add_field(pick_len(4));
    add_field(pick_len(4));
    case (value_class(vt))
      VC_BOOL: frame.push_back(($urandom_range(1) != 0) ? 8'($urandom_range(255)) : 8'd0);
      VC_WORD: repeat (4) frame.push_back(8'($urandom_range(255)));
      VC_PREFIXED: add_field(pick_len(6));
      default: ;
    endcase
  endtask

  task automatic random_frame(input int budget);
    int shape;
    int count;
    int built;
    int keep;
    shape = $urandom_range(99);
    if (shape < 6) begin
      repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(255)));
    end else begin
      frame.push_back((shape < 12) ? 8'($urandom_range(255)) : cfg_version);
      count = ($urandom_range(99) < 5) ? $urandom_range(4, 255) : $urandom_range(0, 3);
      built = (count <= 3) ? count : $urandom_range(0, 2);
      frame.push_back(8'(count));
      repeat (built) add_record();
      repeat ($urandom_range(0, 2)) frame.push_back(8'($urandom_range(255)));
      if ($urandom_range(99) < 10) begin
        keep = $urandom_range(1, frame.size());
        while (frame.size() > keep) void'(frame.pop_back());
      end
    end
    while (frame.size() > budget) void'(frame.pop_back());
    send_frame();
  endtask

  task automatic run_random(input int n, input int idle, input int stall);
    int goal;
    goal = words_sent + n;
    idle_pct = idle;
    stall_pct = stall;
    while (words_sent < goal) random_frame(goal - words_sent);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    // wrong version, then a version byte that already ends the buffer
    frame = '{8'h00};
    send_frame();
    frame = '{8'h01};
    send_frame();
    // no records
    frame = '{8'h01, 8'h00};
    send_frame();
    // bool with all high flag bits, top operator, empty id, trailing byte
    frame = '{8'h01, 8'h01, 8'hF1, 8'h05, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFF, 8'h80, 8'hFF};
    send_frame();
    // unknown value type, then a skipped byte
    frame = '{8'h01, 8'h01, 8'h0E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A};
    send_frame();
    // bad operator
    frame = '{8'h01, 8'h02, 8'h00, 8'h06, 8'h33};
    send_frame();
    // buffer cut short after the operator
    frame = '{8'h01, 8'h01, 8'h06, 8'h01};
    send_frame();
    drain();
  endtask

  task automatic test_idle_mix();
    run_random(120, 0, 0);
    run_random(120, 53, 0);
    run_random(120, 0, 53);
    run_random(120, 25, 25);
    drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 300;
    run_random(80, 0, 0);
    drain();
  endtask

  task automatic test_register_extremes();
    write_config(8'h00, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2);
    run_random(70, 25, 25);
    // colliding codes: earlier match wins
    write_config(8'hFF, 3'd7, 3'd7, 3'd0, 3'd0, 3'd6, 3'd6);
    run_random(70, 25, 25);
    write_config(8'h01, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5);
    run_random(20, 0, 0);
    drain();
  endtask

  initial begin
    cfg_version = 8'h01;
    type_code[tps_pkg::REG_VERSION] = '0;
    type_code[tps_pkg::REG_BOOL] = 3'd0;
    type_code[tps_pkg::REG_INT] = 3'd1;
    type_code[tps_pkg::REG_FLOAT] = 3'd2;
    type_code[tps_pkg::REG_STRING] = 3'd3;
    type_code[tps_pkg::REG_OBJECT] = 3'd4;
    type_code[tps_pkg::REG_ARRAY] = 3'd5;
    clear_parse();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_idle_mix();
    test_backpressure();
    test_register_extremes();
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
